@@ rtl/dpas_pkg.sv @@
// ----------------------------------------------------------------------------
// dpas_pkg
// shared types, constants and a leading-zero count for the binary64 add/sub pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package dpas_pkg;
  localparam logic [63:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX = 11'h7FF;

  // stage 1 -> stage 2: ordered, aligned operands
  typedef struct packed {
    logic        special;
    logic [63:0] special_bits;
    logic        sgn;
    logic        eff_sub;
    logic [10:0] be;
    logic [63:0] av;
    logic [63:0] bv;
  } align_t;

  // stage 2 -> stage 3: raw sum
  typedef struct packed {
    logic        special;
    logic [63:0] special_bits;
    logic        sgn;
    logic [10:0] be;
    logic [63:0] r;
  } sum_t;

  function automatic logic [6:0] lead_zeros(input logic [63:0] v);
    logic [6:0] n;
    logic       found;
    n = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 7'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage
`default_nettype wire

@@ rtl/dpas_align.sv @@
// ----------------------------------------------------------------------------
// dpas_align
// special cases, magnitude ordering and alignment shift
// ----------------------------------------------------------------------------
`default_nettype none
module dpas_align (
  input  wire logic                 action,
  input  wire logic [63:0]          operand_a,
  input  wire logic [63:0]          operand_b,
  output dpas_pkg::align_t          info
);
  logic [63:0] a, b, big, sml, sv, lost_mask;
  logic [10:0] ea, eb, be, se, d;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_zero, b_zero;

  always_comb begin
    a = operand_a;
    b = {operand_b[63] ^ action, operand_b[62:0]};
    ea = a[62:52];
    eb = b[62:52];
    fa = a[51:0];
    fb = b[51:0];
    a_nan = (ea == dpas_pkg::EXP_MAX) && (fa != '0);
    b_nan = (eb == dpas_pkg::EXP_MAX) && (fb != '0);
    a_zero = (a[62:0] == '0);
    b_zero = (b[62:0] == '0);
    lost_mask = '0;
    info = '0;
    info.special = 1'b1;
    if (a_nan || b_nan) begin
      info.special_bits = dpas_pkg::QUIET_NAN;
    end else if (ea == dpas_pkg::EXP_MAX && eb == dpas_pkg::EXP_MAX) begin
      info.special_bits = (a[63] != b[63]) ? dpas_pkg::QUIET_NAN : a;
    end else if (ea == dpas_pkg::EXP_MAX) begin
      info.special_bits = a;
    end else if (eb == dpas_pkg::EXP_MAX) begin
      info.special_bits = b;
    end else if (a_zero && b_zero) begin
      info.special_bits = {a[63] & b[63], 63'd0};
    end else if (a_zero) begin
      info.special_bits = b;
    end else if (b_zero) begin
      info.special_bits = a;
    end else begin
      info.special = 1'b0;
    end
    if (a[62:0] >= b[62:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    be = (big[62:52] != '0) ? big[62:52] : 11'd1;
    se = (sml[62:52] != '0) ? sml[62:52] : 11'd1;
    info.sgn = big[63];
    info.eff_sub = a[63] != b[63];
    info.be = be;
    info.av = {1'b0, (big[62:52] != '0), big[51:0], 10'd0};
    sv = {2'b0, (sml[62:52] != '0), sml[51:0], 9'd0};
    d = be - se;
    if (d >= 11'd62) begin
      info.bv = {63'd0, sv != '0};
    end else begin
      lost_mask = (64'd1 << d[5:0]) - 64'd1;
      info.bv = ((sv >> d[5:0]) << 1) | {63'd0, (sv & lost_mask) != '0};
    end
  end
endmodule
`default_nettype wire

@@ rtl/dpas_norm.sv @@
// ----------------------------------------------------------------------------
// dpas_norm
// leading-zero normalization, underflow, overflow and packing
// ----------------------------------------------------------------------------
`default_nettype none
module dpas_norm (
  input  wire dpas_pkg::sum_t info,
  output      logic [63:0]    result
);
  logic [63:0] r;
  logic [11:0] e;
  logic [6:0]  lz;
  logic [11:0] sh;

  always_comb begin
    r = info.r;
    e = {1'b0, info.be};
    lz = dpas_pkg::lead_zeros(info.r) - 7'd1;
    sh = '0;
    if (info.r[63]) begin
      r = info.r >> 1;
      e = e + 12'd1;
    end else begin
      sh = ({5'd0, lz} < e - 12'd1) ? {5'd0, lz} : e - 12'd1;
      r = info.r << sh[5:0];
      e = e - sh;
    end
    if (!r[62]) e = '0;
    if (info.special) begin
      result = info.special_bits;
    end else if (info.r == '0) begin
      result = '0;
    end else if (e >= {1'b0, dpas_pkg::EXP_MAX}) begin
      result = {info.sgn, dpas_pkg::EXP_MAX, 52'd0};
    end else begin
      result = {info.sgn, e[10:0], r[61:10]};
    end
  end
endmodule
`default_nettype wire

@@ rtl/double_precision_add_sub_core.sv @@
// ----------------------------------------------------------------------------
// double_precision_add_sub_core
// binary64 add/subtract, truncating, three register stages
// ----------------------------------------------------------------------------
// usage:
//   raise start with action, operand_a and operand_b; the transfer happens at
//   the edge where start is high and busy is low. busy is always low, so one
//   operation can enter every cycle.
//   the result appears on sum_bits with done high for exactly one cycle,
//   after it has passed the align, add and normalize registers in turn.
//   throughput is one result per cycle.
//   the receiver cannot stall; results are not held.
//   reset (rst, synchronous) clears the valid pipeline; operations in flight
//   are dropped. the block keeps no other state.
// ----------------------------------------------------------------------------
`default_nettype none
module double_precision_add_sub_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        action,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  output      logic        done,
  output      logic [63:0] sum_bits
);
  dpas_pkg::align_t align_next, align;
  dpas_pkg::sum_t   sum_next, sum;
  logic [63:0]      result_next;
  logic             v1, v2;

  assign busy = 1'b0;

  dpas_align u_align (
    .action(action), .operand_a(operand_a), .operand_b(operand_b),
    .info(align_next)
  );

  always_comb begin
    sum_next.special = align.special;
    sum_next.special_bits = align.special_bits;
    sum_next.sgn = align.sgn;
    sum_next.be = align.be;
    sum_next.r = align.eff_sub ? align.av - align.bv : align.av + align.bv;
  end

  dpas_norm u_norm (.info(sum), .result(result_next));

  always_ff @(posedge clk) begin
    align <= align_next;
    sum <= sum_next;
    sum_bits <= result_next;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      done <= v2;
    end
  end
endmodule
`default_nettype wire

@@ rtl/double_precision_add_sub_checker.sv @@
// ----------------------------------------------------------------------------
// double_precision_add_sub_checker
// port-level checks for the add/sub core
// ----------------------------------------------------------------------------
`default_nettype none
module double_precision_add_sub_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        action,
  input wire logic [63:0] operand_a,
  input wire logic [63:0] operand_b,
  input wire logic        done,
  input wire logic [63:0] sum_bits
);
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done) else $error("missing result");
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3)) else $error("unexpected result");
  a_nan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operand_a[62:52] == 11'h7FF && operand_a[51:0] != '0)
    |-> ##3 (sum_bits == 64'h7FF8_0000_0000_0000)) else $error("nan result");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

bind double_precision_add_sub_core double_precision_add_sub_checker u_checker (.*);
`default_nettype wire

@@ tb/sv/tb_double_precision_add_sub_core.sv @@
// ----------------------------------------------------------------------------
// tb_double_precision_add_sub_core
// self-checking bench for the binary64 add/subtract core: directed special
// cases then random operands, results compared against a local truncating
// adder model in arrival order
// ----------------------------------------------------------------------------
`default_nettype none
module tb_double_precision_add_sub_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        action;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        action = 1'b0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        done;
  logic [63:0] sum_bits;

  op_t         pending_ops[$];
  logic [63:0] expected_sums[$];
  int          errors = 0;
  int          idle_left = 0;
  bit          quiet_tail = 1'b0;
  bit          stim_done = 1'b0;

  double_precision_add_sub_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .operand_a(operand_a), .operand_b(operand_b), .done(done), .sum_bits(sum_bits)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] trunc_add(logic [63:0] a, logic [63:0] b);
    logic [10:0] ea, eb;
    logic [51:0] fa, fb;
    logic [63:0] big, sml, av, sv, bv, r, lost;
    logic [63:0] be, se, bm, sm, d, e, lz, sh;
    logic        sgn;
    ea = a[62:52]; eb = b[62:52]; fa = a[51:0]; fb = b[51:0];
    if ((ea == dpas_pkg::EXP_MAX && fa != 0) || (eb == dpas_pkg::EXP_MAX && fb != 0))
      return dpas_pkg::QUIET_NAN;
    if (ea == dpas_pkg::EXP_MAX && eb == dpas_pkg::EXP_MAX)
      return (a[63] != b[63]) ? dpas_pkg::QUIET_NAN : a;
    if (ea == dpas_pkg::EXP_MAX) return a;
    if (eb == dpas_pkg::EXP_MAX) return b;
    if (a[62:0] == 0 && b[62:0] == 0) return {a[63] & b[63], 63'b0};
    if (a[62:0] == 0) return b;
    if (b[62:0] == 0) return a;
    if (a[62:0] >= b[62:0]) begin
      big = a; sml = b;
    end else begin
      big = b; sml = a;
    end
    sgn = big[63];
    be = 64'(big[62:52]); bm = 64'(big[51:0]);
    se = 64'(sml[62:52]); sm = 64'(sml[51:0]);
    if (be != 0) bm[52] = 1'b1; else be = 64'd1;
    if (se != 0) sm[52] = 1'b1; else se = 64'd1;
    av = bm << 10;
    sv = sm << 9;
    d = be - se;
    if (d >= 62) begin
      bv = (sv != 0) ? 64'd1 : 64'd0;
    end else begin
      lost = sv & ((64'd1 << d) - 64'd1);
      bv = ((sv >> d) << 1) | 64'(lost != 0);
    end
    if (a[63] == b[63]) begin
      r = av + bv;
    end else begin
      r = av - bv;
      if (r == 0) return 64'd0;
    end
    e = be;
    if (r[63]) begin
      r = r >> 1; e = e + 64'd1;
    end else begin
      lz = '0;
      while (lz < 64 && r[63 - lz] == 1'b0) lz++;
      lz = lz - 64'd1;
      sh = (lz < e - 64'd1) ? lz : e - 64'd1;
      r = r << sh; e = e - sh;
    end
    if (!r[62]) e = '0;
    if (e >= 2047) return {sgn, dpas_pkg::EXP_MAX, 52'b0};
    return {sgn, e[10:0], r[61:10]};
  endfunction

  function automatic logic [63:0] rand_fp(bit full);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, full ? 9 : 5))
      0: v[62:52] = 11'd0;
      1: v[62:52] = 11'd1;
      2: v[62:52] = 11'h7FE;
      3: v[62:52] = 11'(1023 + $urandom_range(0, 8) - 4);
      6: v[62:0] = 63'd0;
      7: v[62:52] = dpas_pkg::EXP_MAX;
      8: v[62:0] = {dpas_pkg::EXP_MAX, 52'd0};
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_op(logic act, logic [63:0] a, logic [63:0] b);
    op_t o;
    o.action = act; o.operand_a = a; o.operand_b = b;
    pending_ops.push_back(o);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_sums.push_back(trunc_add(operand_a,
          {operand_b[63] ^ action, operand_b[62:0]}));
        pending_ops.pop_front();
      end
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        idle_left <= $urandom_range(1, 11) - 1;
        start <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op_t o;
        o = pending_ops[0];
        start <= 1'b1;
        action <= o.action;
        operand_a <= o.operand_a;
        operand_b <= o.operand_b;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected transfer: sum_bits actual %h", sum_bits);
        errors++;
      end else begin
        logic [63:0] exp_sum;
        exp_sum = expected_sums.pop_front();
        if (sum_bits !== exp_sum) begin
          $error("sum_bits mismatch: expected %h actual %h", exp_sum, sum_bits);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [63:0] x, y;
    push_op(1'b0, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_op(1'b1, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_op(1'b0, 64'h7FF8_0000_0000_0001, 64'h3FF0_0000_0000_0000);
    push_op(1'b0, 64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0001);
    push_op(1'b0, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
    push_op(1'b1, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
    push_op(1'b0, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
    push_op(1'b0, 64'hFFF0_0000_0000_0000, 64'h4000_0000_0000_0000);
    push_op(1'b0, 64'h4000_0000_0000_0000, 64'h7FF0_0000_0000_0000);
    push_op(1'b0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    push_op(1'b0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
    push_op(1'b1, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
    push_op(1'b0, 64'h0000_0000_0000_0000, 64'hC010_0000_0000_0001);
    push_op(1'b1, 64'hC010_0000_0000_0001, 64'h8000_0000_0000_0000);
    push_op(1'b0, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
    push_op(1'b1, 64'hFFEF_FFFF_FFFF_FFFF, 64'h7FE0_0000_0000_0000);
    push_op(1'b1, 64'h0010_0000_0000_0000, 64'h000F_FFFF_FFFF_FFFF);
    push_op(1'b1, 64'h0010_0000_0000_0001, 64'h0010_0000_0000_0000);
    push_op(1'b0, 64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
    push_op(1'b1, 64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000);
    push_op(1'b0, 64'h4340_0000_0000_0000, 64'hBCA0_0000_0000_0001);
    push_op(1'b0, 64'h7FE0_0000_0000_0000, 64'h0000_0000_0000_0001);
    push_op(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
    for (int i = 0; i < 1600; i++) begin
      x = rand_fp(i % 4 == 0);
      y = rand_fp(i % 4 == 0);
      if (i % 5 == 0) y[62:52] = x[62:52];
      if (i % 11 == 0) y[62:0] = x[62:0] ^ 63'($urandom_range(0, 3));
      push_op(1'($urandom_range(0, 1)), x, y);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() < 200);
    quiet_tail = 1'b1;
    wait (pending_ops.size() == 0 && !start);
    wait (expected_sums.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
